/* rtl/chunked_body_decoder_defines.svh */
// assertion helpers for the chunked body decoder
`ifndef CHUNKED_BODY_DECODER_DEFINES_SVH
`define CHUNKED_BODY_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define CBD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cbd assertion failed");

// next-cycle implication, disabled while in reset
`define CBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cbd assertion failed");

`else

`define CBD_ASSERT_SAME(label, clk, rstn, ante, cons)
`define CBD_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* rtl/cbd_pkg.sv */
`timescale 1ns / 1ps

package cbd_pkg;

    // decoder phases, one-hot
    typedef enum logic [6:0] {
        PH_SIZE    = 7'b0000001,
        PH_DATA    = 7'b0000010,
        PH_END_CR  = 7'b0000100,
        PH_END_LF  = 7'b0001000,
        PH_DONE    = 7'b0010000,
        PH_FMT_ERR = 7'b0100000,
        PH_BIG_ERR = 7'b1000000
    } cbd_phase_t;

    // result status codes
    localparam logic [1:0] ST_MORE     = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_FORMAT   = 2'd2;
    localparam logic [1:0] ST_BIG      = 2'd3;

    // characters of interest
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    localparam int CFG_WIDTH  = 32;
    localparam int BYTE_WIDTH = 8;

    // one result item
    typedef struct packed {
        logic [1:0] status;
        logic       payload_valid;
        logic [7:0] payload_byte;
    } cbd_result_t;

endpackage

/* rtl/cbd_core.sv */
`timescale 1ns / 1ps

module cbd_core
    import cbd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_WIDTH-1:0]  cfg_wr_data,
    input  logic                  step_en,
    input  logic [BYTE_WIDTH-1:0] step_byte,
    output cbd_result_t           step_result
);

    localparam int SUM_W = (COUNT_WIDTH >= CFG_WIDTH) ? COUNT_WIDTH + 1 : CFG_WIDTH + 1;

    // hex digit decode: bit 4 marks a digit, low bits give its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, 4'(c - 8'h30)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                r = {1'b1, 4'(c - 8'h57)};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                r = {1'b1, 4'(c - 8'h37)};
            end
            return r;
        end
    endfunction

    logic [CFG_WIDTH-1:0]   max_size_reg;
    cbd_phase_t             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] chunk_len_reg, chunk_len_next;
    logic [COUNT_WIDTH-1:0] done_cnt_reg, done_cnt_next;
    logic [COUNT_WIDTH-1:0] body_total_reg, body_total_next;
    logic                   seen_digit_reg, seen_digit_next;
    logic                   digits_ended_reg, digits_ended_next;
    logic                   prev_cr_reg, prev_cr_next;

    logic [4:0]             hex;
    logic [SUM_W-1:0]       total_sum;
    logic                   too_big;
    logic [COUNT_WIDTH-1:0] done_inc;

    assign hex       = hex_decode(step_byte);
    assign total_sum = SUM_W'(body_total_reg) + SUM_W'(chunk_len_reg);
    assign too_big   = total_sum > SUM_W'(max_size_reg);
    assign done_inc  = done_cnt_reg + COUNT_WIDTH'(1);

    // next state and result for one byte
    always_comb begin
        phase_next        = phase_reg;
        chunk_len_next    = chunk_len_reg;
        done_cnt_next     = done_cnt_reg;
        body_total_next   = body_total_reg;
        seen_digit_next   = seen_digit_reg;
        digits_ended_next = digits_ended_reg;
        prev_cr_next      = prev_cr_reg;
        step_result       = '{status: ST_MORE, payload_valid: 1'b0, payload_byte: 8'd0};

        case (phase_reg)
            PH_SIZE: begin
                if (step_byte == CHAR_LF && prev_cr_reg) begin
                    if (!seen_digit_reg) begin
                        phase_next         = PH_FMT_ERR;
                        step_result.status = ST_FORMAT;
                    end else if (too_big) begin
                        phase_next         = PH_BIG_ERR;
                        step_result.status = ST_BIG;
                    end else begin
                        done_cnt_next = '0;
                        phase_next    = (chunk_len_reg == '0) ? PH_END_CR : PH_DATA;
                    end
                end else if (step_byte == CHAR_CR) begin
                    prev_cr_next      = 1'b1;
                    digits_ended_next = 1'b1;
                end else begin
                    prev_cr_next = 1'b0;
                    if (digits_ended_reg) begin
                        // rest of the line is ignored
                    end else if (!seen_digit_reg &&
                                 (step_byte == CHAR_SPACE || step_byte == CHAR_TAB)) begin
                        // leading blank
                    end else if (!hex[4]) begin
                        digits_ended_next = 1'b1;
                    end else if (|chunk_len_reg[COUNT_WIDTH-1 -: 4]) begin
                        // another digit would overflow the length
                        phase_next         = PH_FMT_ERR;
                        step_result.status = ST_FORMAT;
                    end else begin
                        chunk_len_next  = {chunk_len_reg[COUNT_WIDTH-5:0], hex[3:0]};
                        seen_digit_next = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                step_result.payload_byte  = step_byte;
                step_result.payload_valid = 1'b1;
                done_cnt_next             = done_inc;
                if (body_total_reg != '1) begin
                    body_total_next = body_total_reg + COUNT_WIDTH'(1);
                end
                if (done_inc >= chunk_len_reg) begin
                    phase_next = PH_END_CR;
                end
            end
            PH_END_CR: begin
                if (step_byte == CHAR_CR) begin
                    phase_next = PH_END_LF;
                end else begin
                    phase_next         = PH_FMT_ERR;
                    step_result.status = ST_FORMAT;
                end
            end
            PH_END_LF: begin
                if (step_byte != CHAR_LF) begin
                    phase_next         = PH_FMT_ERR;
                    step_result.status = ST_FORMAT;
                end else if (chunk_len_reg == '0) begin
                    phase_next         = PH_DONE;
                    step_result.status = ST_COMPLETE;
                end else begin
                    // start the next size line
                    phase_next        = PH_SIZE;
                    chunk_len_next    = '0;
                    done_cnt_next     = '0;
                    seen_digit_next   = 1'b0;
                    digits_ended_next = 1'b0;
                    prev_cr_next      = 1'b0;
                end
            end
            PH_DONE: begin
                step_result.status = ST_COMPLETE;
            end
            PH_BIG_ERR: begin
                step_result.status = ST_BIG;
            end
            default: begin
                phase_next         = PH_FMT_ERR;
                step_result.status = ST_FORMAT;
            end
        endcase
    end

    // limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg <= '0;
        end else if (cfg_wr_en) begin
            max_size_reg <= cfg_wr_data;
        end
    end

    // decoder state, updated once per processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SIZE;
            chunk_len_reg    <= '0;
            done_cnt_reg     <= '0;
            body_total_reg   <= '0;
            seen_digit_reg   <= 1'b0;
            digits_ended_reg <= 1'b0;
            prev_cr_reg      <= 1'b0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            chunk_len_reg    <= chunk_len_next;
            done_cnt_reg     <= done_cnt_next;
            body_total_reg   <= body_total_next;
            seen_digit_reg   <= seen_digit_next;
            digits_ended_reg <= digits_ended_next;
            prev_cr_reg      <= prev_cr_next;
        end
    end

endmodule

/* rtl/chunked_body_decoder.sv */
`timescale 1ns / 1ps

// Chunked body decoder: takes the raw bytes of an HTTP chunked body, one per request on
// s_axis, and gives one result per input byte on m_axis: the payload byte (zero when the
// byte is framing), a payload flag and a status (0 need more, 1 complete, 2 format error,
// 3 body too large). Errors and completion are sticky until reset. cfg_wr_en/cfg_wr_data
// set the largest total payload size; write it while the stream is idle. Throughput is one
// byte per clock unless m_axis_tready stalls the output; each byte passes the input register
// and then the result register, with all per-byte decode and counter update combinational
// between them: each byte depends on the state the previous byte leaves. No start-up sweep.

`include "chunked_body_decoder_defines.svh"

module chunked_body_decoder
    import cbd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_WIDTH-1:0] cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] payload_byte
    output logic [2:0]           m_axis_tuser    // [0] payload_valid, [2:1] status
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    cbd_result_t out_result_reg;
    cbd_result_t core_result;
    logic        out_ready;
    logic        advance;

    // stage handshake
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // decode step
    cbd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (advance),
        .step_byte   (in_byte_reg),
        .step_result (core_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_result_reg.payload_byte;
    assign m_axis_tuser  = {out_result_reg.status, out_result_reg.payload_valid};

    // payload only while the body is still open
    `CBD_ASSERT_SAME(a_payload_status, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[2:1] == ST_MORE)
    // framing bytes give a zero data field
    `CBD_ASSERT_SAME(a_framing_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'd0)
    // an empty result register never holds off the input side
    `CBD_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_axis_tvalid, s_axis_tready)
    // a held byte stays in the input register until it is processed
    `CBD_ASSERT_NEXT(a_stage_holds, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import cbd_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    // how the two sides idle during a phase
    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_e;

    // how the body ends; errors and completion are sticky, so one per run
    typedef enum int {
        END_COMPLETE,
        END_NO_DIGITS,
        END_OVERFLOW,
        END_TOO_LARGE,
        END_BAD_CR,
        END_BAD_LF
    } body_end_e;

    typedef enum int {
        ROW_BYTE,
        ROW_CFG
    } row_kind_e;

    typedef struct {
        row_kind_e   kind;
        logic [31:0] value;
        bit          use_typed;
        cbd_result_t typed;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] payload_byte
    logic [2:0]  m_axis_tuser;         // [0] payload_valid, [2:1] status

    // decoder state as seen by the predictor
    cbd_phase_t  ph;
    logic [31:0] max_size;
    logic [31:0] chunk_len;
    logic [31:0] chunk_cnt;
    logic [31:0] body_total;
    bit          seen_digit;
    bit          digits_done;
    bit          prev_cr;

    cbd_result_t pending_results[$];
    dir_row_t    dir_rows[$];
    cbd_result_t want;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          sent_count = 0;

    chunked_body_decoder u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    function automatic void new_line();
        chunk_len   = '0;
        chunk_cnt   = '0;
        seen_digit  = 1'b0;
        digits_done = 1'b0;
        prev_cr     = 1'b0;
    endfunction

    // expected result of one raw byte, advancing the predictor state
    function automatic cbd_result_t decode_byte(logic [7:0] c);
        cbd_result_t r;
        int          v;
        logic [63:0] lim;
        r = '0;
        r.status = ST_MORE;
        lim = {32'd0, max_size};
        case (ph)
            PH_SIZE: begin
                if (c == CHAR_LF && prev_cr) begin
                    if (!seen_digit) begin
                        ph = PH_FMT_ERR;
                        r.status = ST_FORMAT;
                    end else if ({32'd0, body_total} > lim ||
                                 {32'd0, chunk_len} > lim - {32'd0, body_total}) begin
                        ph = PH_BIG_ERR;
                        r.status = ST_BIG;
                    end else begin
                        chunk_cnt = '0;
                        if (chunk_len == 0) ph = PH_END_CR;
                        else ph = PH_DATA;
                    end
                end else if (c == CHAR_CR) begin
                    prev_cr = 1'b1;
                    digits_done = 1'b1;
                end else begin
                    prev_cr = 1'b0;
                    v = hex_value(c);
                    if (digits_done ||
                        (!seen_digit && (c == CHAR_SPACE || c == CHAR_TAB))) begin
                        // ignored byte
                    end else if (v < 0) begin
                        digits_done = 1'b1;
                    end else if (chunk_len > 32'h0FFF_FFFF) begin
                        ph = PH_FMT_ERR;
                        r.status = ST_FORMAT;
                    end else begin
                        chunk_len = {chunk_len[27:0], 4'(v)};
                        seen_digit = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                r.payload_byte = c;
                r.payload_valid = 1'b1;
                chunk_cnt = chunk_cnt + 1;
                if (body_total != '1) body_total = body_total + 1;
                if (chunk_cnt >= chunk_len) ph = PH_END_CR;
            end
            PH_END_CR: begin
                if (c == CHAR_CR) begin
                    ph = PH_END_LF;
                end else begin
                    ph = PH_FMT_ERR;
                    r.status = ST_FORMAT;
                end
            end
            PH_END_LF: begin
                if (c != CHAR_LF) begin
                    ph = PH_FMT_ERR;
                    r.status = ST_FORMAT;
                end else if (chunk_len == 0) begin
                    ph = PH_DONE;
                    r.status = ST_COMPLETE;
                end else begin
                    new_line();
                    ph = PH_SIZE;
                end
            end
            PH_DONE:    r.status = ST_COMPLETE;
            PH_BIG_ERR: r.status = ST_BIG;
            default: begin
                ph = PH_FMT_ERR;
                r.status = ST_FORMAT;
            end
        endcase
        return r;
    endfunction

    function automatic void set_idling(idle_mode_e m);
        case (m)
            IDLE_NONE: begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin gap_pct = 68; stall_pct = 0;  end
            IDLE_RECV: begin gap_pct = 0;  stall_pct = 68; end
            default:   begin gap_pct = 17; stall_pct = 17; end
        endcase
    endfunction

    function automatic void add_row(row_kind_e kind, logic [31:0] value,
                                    bit use_typed, cbd_result_t typed);
        dir_row_t row;
        row.kind = kind;
        row.value = value;
        row.use_typed = use_typed;
        row.typed = typed;
        dir_rows.push_back(row);
    endfunction

    // one request on the input side, with random gaps before it
    task automatic send_byte(input logic [7:0] b, input bit use_typed = 1'b0,
                             input cbd_result_t typed = '0);
        cbd_result_t r;
        while ($urandom_range(1, 100) <= gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        r = decode_byte(b);
        pending_results.push_back(use_typed ? typed : r);
        sent_count++;
    endtask

    // register write once the stream has drained
    task automatic write_max(input logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        max_size = v;
    endtask

    // size line with random whitespace, leading zeros, letter case and extension
    task automatic send_size_line(input logic [31:0] size);
        int         ndig;
        int         i;
        logic [7:0] jb;
        ndig = 1;
        while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
        repeat ($urandom_range(0, 2))
            send_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
        repeat ($urandom_range(0, 3)) send_byte("0");
        for (i = ndig - 1; i >= 0; i--)
            send_byte(hex_char(size[4 * i +: 4], 1'($urandom_range(0, 1))));
        if ($urandom_range(0, 2) == 0) begin
            send_byte($urandom_range(0, 1) ? 8'(";") : CHAR_SPACE);
            repeat ($urandom_range(0, 6)) begin
                jb = 8'($urandom_range(0, 255));
                // a bare cr inside the extension, broken up so it does not end the line
                if (jb == CHAR_CR) begin
                    send_byte(CHAR_CR);
                    send_byte(";");
                end else begin
                    send_byte(jb);
                end
            end
        end
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    // result side: random stalls and checking against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result: byte %02h valid %0b status %0d",
                             m_axis_tdata, m_axis_tuser[0], m_axis_tuser[2:1]);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (want.payload_byte !== m_axis_tdata ||
                    want.payload_valid !== m_axis_tuser[0] ||
                    want.status !== m_axis_tuser[2:1]) begin
                    if (fail_count < 10)
                        $display({"mismatch: expected byte %02h valid %0b status %0d, ",
                                  "got byte %02h valid %0b status %0d"},
                                 want.payload_byte, want.payload_valid, want.status,
                                 m_axis_tdata, m_axis_tuser[0], m_axis_tuser[2:1]);
                    fail_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(1, 100) > stall_pct);
    end

    // watchdog on cycles without any request moving
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        int          p;
        int          r;
        int          k;
        int          phase_start;
        logic [31:0] size;
        logic [31:0] room;
        bit          exact;
        logic [7:0]  b;
        body_end_e   ending;

        ph = PH_SIZE;
        max_size = '0;
        body_total = '0;
        new_line();

        // directed: whitespace, junk, ignored digit, bare lf and cr, extreme payload bytes,
        // limit dropped to zero and raised again in the middle of a chunk
        add_row(ROW_BYTE, 32'(CHAR_SPACE), 1'b1, {ST_MORE, 1'b0, 8'h00});
        add_row(ROW_CFG, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(ROW_BYTE, 32'(CHAR_TAB), 1'b0, '0);
        add_row(ROW_BYTE, 32'("0"), 1'b0, '0);
        add_row(ROW_BYTE, 32'("2"), 1'b0, '0);
        add_row(ROW_BYTE, 32'(";"), 1'b0, '0);
        add_row(ROW_BYTE, 32'("F"), 1'b0, '0);
        add_row(ROW_BYTE, 32'(CHAR_LF), 1'b0, '0);
        add_row(ROW_BYTE, 32'(CHAR_CR), 1'b0, '0);
        add_row(ROW_BYTE, 32'("x"), 1'b0, '0);
        add_row(ROW_BYTE, 32'(CHAR_CR), 1'b0, '0);
        add_row(ROW_BYTE, 32'(CHAR_LF), 1'b0, '0);
        add_row(ROW_BYTE, 32'h0000_0000, 1'b1, {ST_MORE, 1'b1, 8'h00});
        add_row(ROW_CFG, 32'h0000_0000, 1'b0, '0);
        add_row(ROW_BYTE, 32'h0000_00FF, 1'b1, {ST_MORE, 1'b1, 8'hFF});
        add_row(ROW_CFG, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(ROW_BYTE, 32'(CHAR_CR), 1'b0, '0);
        add_row(ROW_BYTE, 32'(CHAR_LF), 1'b0, '0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(IDLE_NONE);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_max(dir_rows[i].value);
            else
                send_byte(dir_rows[i].value[7:0], dir_rows[i].use_typed, dir_rows[i].typed);
        end

        // random well-formed chunks, a new limit and idling pattern per phase
        for (p = 0; p < 8; p++) begin
            set_idling(idle_mode_e'(p % 4));
            exact = 1'b0;
            r = $urandom_range(0, 3);
            if (r == 0) begin
                write_max(32'hFFFF_FFFF);
            end else if (r == 3) begin
                write_max(body_total + $urandom_range(1, 40));
                exact = 1'b1;
            end else begin
                write_max(body_total + $urandom_range(1000, 3000));
            end
            phase_start = sent_count;
            while (sent_count - phase_start < 120 && max_size != body_total) begin
                room = max_size - body_total;
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                   : $urandom_range(1, 40);
                // a tight limit is filled exactly by the first chunk
                if (exact || size > room) size = room;
                exact = 1'b0;
                send_size_line(size);
                repeat (size) send_byte(8'($urandom_range(0, 255)));
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
        end

        // end of body: completion or one of the sticky errors
        set_idling(idle_mode_e'($urandom_range(0, 3)));
        write_max(32'hFFFF_FFFF);
        ending = body_end_e'($urandom_range(0, 5));
        case (ending)
            END_COMPLETE: begin
                send_size_line(32'd0);
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            END_NO_DIGITS: begin
                send_byte(CHAR_SPACE);
                send_byte(";");
                send_byte("a");
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            END_OVERFLOW: begin
                send_byte("1");
                repeat (8) send_byte("0");
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            END_TOO_LARGE: begin
                case ($urandom_range(0, 3))
                    0: begin
                        write_max(32'd0);
                        send_size_line(32'd1);
                    end
                    1: begin
                        k = $urandom_range(0, 20);
                        write_max(body_total + k);
                        send_size_line(k + 1);
                    end
                    2: begin
                        // full-precision sum past the top of the register
                        send_size_line(32'hFFFF_FFFF);
                    end
                    default: begin
                        // zero size chunk after the limit drops below the total
                        write_max(body_total - 1);
                        send_size_line(32'd0);
                    end
                endcase
            end
            END_BAD_CR: begin
                send_size_line(32'd3);
                repeat (3) send_byte(8'($urandom_range(0, 255)));
                b = 8'($urandom_range(0, 255));
                send_byte((b == CHAR_CR) ? CHAR_LF : b);
            end
            default: begin
                send_size_line(32'd1);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(CHAR_CR);
                b = 8'($urandom_range(0, 255));
                send_byte((b == CHAR_LF) ? CHAR_CR : b);
            end
        endcase

        // trailing bytes after the sticky state
        repeat ($urandom_range(10, 30)) send_byte(8'($urandom_range(0, 255)));

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
